FILE: src/hyst_pkg.sv
package hyst_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HEAT   = 2'd1,
    MODE_COOL   = 2'd2
  } mode_t;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_RAISE  = 2'd1;
  localparam logic [1:0] OP_LOWER  = 2'd2;

  localparam logic [2:0] REG_FORCED_HEAT_LEVEL = 3'd0;
  localparam logic [2:0] REG_BAND              = 3'd1;
  localparam logic [2:0] REG_SETPOINT_STEP     = 3'd2;
  localparam logic [2:0] REG_SETPOINT_MAX      = 3'd3;
  localparam logic [2:0] REG_SETPOINT_MIN      = 3'd4;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned FHL_W   = 12;
  localparam int unsigned BAND_W  = 8;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned SP_W    = 11;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [FHL_W-1:0] FORCED_HEAT_LEVEL_RST = 12'sd95;
  localparam logic [BAND_W-1:0]       BAND_RST              = 8'd5;
  localparam logic [STEP_W-1:0]       SETPOINT_STEP_RST     = 8'd5;
  localparam logic [SP_W-1:0]         SETPOINT_MAX_RST      = 11'd390;
  localparam logic [SP_W-1:0]         SETPOINT_MIN_RST      = 11'd100;
  localparam logic [SP_W-1:0]         SET_POINT_RST         = 11'd220;

  // sixteenths to tenths, truncated
  function automatic logic [3:0] frac_tenths(input logic [3:0] f);
    logic [7:0] p;
    p = {4'd0, f} * 8'd10;
    return p[7:4];
  endfunction

  // raw two's complement sixteenths to signed tenths
  function automatic logic signed [TEMP_W-1:0] to_tenths(input logic [15:0] raw);
    logic        neg;
    logic [15:0] mag;
    logic [15:0] t;
    neg = raw[15];
    mag = neg ? 16'(~raw + 16'd1) : raw;
    t   = 16'({4'd0, mag[15:4]} * 16'd10) + {12'd0, frac_tenths(mag[3:0])};
    return neg ? $signed(16'(-t)) : $signed(t);
  endfunction

endpackage

FILE: src/hysteresis_thermostat.sv
// Heat/cool thermostat with hysteresis. Each command beat is a sensor sample
// (converted from sixteenths to tenths of a degree, then run through the
// regulator) or a raise/lower of the set point by setpoint_step, clamped to
// setpoint_max/setpoint_min. Every command gives exactly one result beat with
// the mode and set point after it. A command beat can be taken every cycle;
// the result beat passes through the input stage (conversion) and then the
// result stage (regulation and set point update), and the command side stalls
// only while both stages hold a beat and res_ready is low.
// Configuration writes are taken at once (cfg_ready is always high) and are
// meant for an idle block.
module hysteresis_thermostat
  import hyst_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [1:0]                  opcode,
  input  logic [15:0]                 sensor_raw,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [1:0]                  mode,
  output logic                        mode_changed,
  output logic signed [TEMP_W-1:0]    measured_tenths,
  output logic [SP_W-1:0]             set_point
);

  logic signed [FHL_W-1:0] forced_heat_level;
  logic [BAND_W-1:0]       band;
  logic [STEP_W-1:0]       setpoint_step;
  logic [SP_W-1:0]         setpoint_max;
  logic [SP_W-1:0]         setpoint_min;

  mode_t                   mode_reg, mode_next;
  logic [SP_W-1:0]         set_point_reg, set_point_next;

  logic                    s1_valid;
  logic [1:0]              s1_op;
  logic signed [TEMP_W-1:0] s1_meas;

  logic                    advance;
  logic signed [TEMP_W:0]  gap;
  logic signed [TEMP_W:0]  band_s;
  logic                    forced;
  logic [SP_W:0]           raised;
  logic signed [SP_W+1:0]  lowered;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || advance;

  // state after a step is what the result shows
  assign mode      = mode_reg;
  assign set_point = set_point_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_heat_level <= FORCED_HEAT_LEVEL_RST;
      band              <= BAND_RST;
      setpoint_step     <= SETPOINT_STEP_RST;
      setpoint_max      <= SETPOINT_MAX_RST;
      setpoint_min      <= SETPOINT_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORCED_HEAT_LEVEL: forced_heat_level <= $signed(cfg_data[FHL_W-1:0]);
        REG_BAND:              band              <= cfg_data[BAND_W-1:0];
        REG_SETPOINT_STEP:     setpoint_step     <= cfg_data[STEP_W-1:0];
        REG_SETPOINT_MAX:      setpoint_max      <= cfg_data[SP_W-1:0];
        REG_SETPOINT_MIN:      setpoint_min      <= cfg_data[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage: conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
    if (cmd_valid && cmd_ready) begin
      s1_op   <= opcode;
      s1_meas <= (opcode == OP_SAMPLE) ? to_tenths(sensor_raw) : '0;
    end
  end

  assign gap     = $signed({{(TEMP_W+1-SP_W){1'b0}}, set_point_reg})
                 - $signed({s1_meas[TEMP_W-1], s1_meas});
  assign band_s  = $signed({{(TEMP_W+1-BAND_W){1'b0}}, band});
  assign forced  = s1_meas <= TEMP_W'(forced_heat_level);
  assign raised  = {1'b0, set_point_reg} + {{(SP_W+1-STEP_W){1'b0}}, setpoint_step};
  assign lowered = $signed({2'b00, set_point_reg})
                 - $signed({{(SP_W+2-STEP_W){1'b0}}, setpoint_step});

  always_comb begin
    mode_next      = mode_reg;
    set_point_next = set_point_reg;
    unique case (s1_op)
      OP_SAMPLE: begin
        if (forced) begin
          mode_next = MODE_HEAT;
        end else begin
          unique case (mode_reg)
            MODE_NORMAL: begin
              if (gap > 0 && gap >= band_s) begin
                mode_next = MODE_HEAT;
              end else if (gap <= 0 && gap <= -band_s) begin
                mode_next = MODE_COOL;
              end
            end
            MODE_HEAT: if (gap <= 0) mode_next = MODE_NORMAL;
            MODE_COOL: if (gap >= 0) mode_next = MODE_NORMAL;
            default: ;
          endcase
        end
      end
      OP_RAISE: begin
        set_point_next = (raised > {1'b0, setpoint_max}) ? setpoint_max : raised[SP_W-1:0];
      end
      OP_LOWER: begin
        set_point_next = (lowered < $signed({2'b00, setpoint_min})) ? setpoint_min
                       : lowered[SP_W-1:0];
      end
      default: ;
    endcase
  end

  // result stage: regulation and set point
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      mode_reg      <= MODE_NORMAL;
      set_point_reg <= SET_POINT_RST;
    end else begin
      if (res_ready || !res_valid) begin
        res_valid <= s1_valid;
      end
      if (advance) begin
        mode_reg      <= mode_next;
        set_point_reg <= set_point_next;
      end
    end
    if (advance) begin
      mode_changed    <= (mode_next != mode_reg);
      measured_tenths <= s1_meas;
    end
  end

  a_no_mode_change_on_setpoint: assert property (@(posedge clk) disable iff (rst)
    advance && s1_op != OP_SAMPLE |=> !mode_changed && measured_tenths == 0)
    else $error("set point command changed mode or measurement");

  a_forced_heat: assert property (@(posedge clk) disable iff (rst)
    advance && s1_op == OP_SAMPLE && forced |=> mode == MODE_HEAT)
    else $error("forced heat level not honored");

  a_sample_keeps_setpoint: assert property (@(posedge clk) disable iff (rst)
    advance && s1_op == OP_SAMPLE |=> set_point == $past(set_point_reg))
    else $error("sample changed set point");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> s1_valid && res_valid && !res_ready)
    else $error("command side stalled with room in the pipe");

endmodule

FILE: tb/hysteresis_thermostat_tb.sv
`timescale 1ns / 100ps

module hysteresis_thermostat_tb;
  import hyst_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int STALL_LIMIT = 400;

  typedef struct {
    mode_t                     mode;
    logic                      changed;
    logic signed [TEMP_W-1:0]  tenths;
    logic [SP_W-1:0]           sp;
  } thermo_result_t;

  class thermo_scoreboard;
    logic signed [FHL_W-1:0] heat_floor;
    logic [BAND_W-1:0]       band;
    logic [STEP_W-1:0]       step;
    logic [SP_W-1:0]         sp_max;
    logic [SP_W-1:0]         sp_min;
    mode_t                   mode_q;
    logic [SP_W-1:0]         sp_q;
    thermo_result_t          want_q[$];
    int unsigned             errors;

    function new();
      heat_floor = 12'sd95;
      band       = 8'd5;
      step       = 8'd5;
      sp_max     = 11'd390;
      sp_min     = 11'd100;
      mode_q     = MODE_NORMAL;
      sp_q       = 11'd220;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_FORCED_HEAT_LEVEL: heat_floor = $signed(d[FHL_W-1:0]);
        REG_BAND:              band = d[BAND_W-1:0];
        REG_SETPOINT_STEP:     step = d[STEP_W-1:0];
        REG_SETPOINT_MAX:      sp_max = d[SP_W-1:0];
        REG_SETPOINT_MIN:      sp_min = d[SP_W-1:0];
        default: ;
      endcase
    endfunction

    // sixteenths to tenths on the magnitude, truncated, sign restored
    function int sensor_to_tenths(logic [15:0] raw);
      logic [15:0] mag;
      int t;
      mag = raw[15] ? 16'(~raw + 16'd1) : raw;
      t = int'(mag >> 4) * 10 + (int'(mag[3:0]) * 10) / 16;
      return raw[15] ? -t : t;
    endfunction

    function void note_command(logic [1:0] op, logic [15:0] raw);
      int meas;
      int gap;
      int mag;
      int v;
      mode_t prev;
      thermo_result_t r;
      prev = mode_q;
      meas = 0;
      case (op)
        OP_SAMPLE: begin
          meas = sensor_to_tenths(raw);
          if (meas <= int'(heat_floor)) begin
            mode_q = MODE_HEAT;
          end else begin
            gap = int'(sp_q) - meas;
            mag = gap < 0 ? -gap : gap;
            case (mode_q)
              MODE_NORMAL: begin
                if (mag >= int'(band)) mode_q = (gap > 0) ? MODE_HEAT : MODE_COOL;
              end
              MODE_HEAT: begin
                if (gap <= 0) mode_q = MODE_NORMAL;
              end
              MODE_COOL: begin
                if (gap >= 0) mode_q = MODE_NORMAL;
              end
              default: ;
            endcase
          end
        end
        OP_RAISE: begin
          v = int'(sp_q) + int'(step);
          if (v > int'(sp_max)) v = int'(sp_max);
          sp_q = 11'(v);
        end
        OP_LOWER: begin
          v = int'(sp_q) - int'(step);
          if (v < int'(sp_min)) v = int'(sp_min);
          sp_q = 11'(v);
        end
        default: ;
      endcase
      r.mode    = mode_q;
      r.changed = (mode_q != prev);
      r.tenths  = 16'(meas);
      r.sp      = sp_q;
      want_q.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [1:0] m, logic mc, logic signed [TEMP_W-1:0] t,
                      logic [SP_W-1:0] sp);
      thermo_result_t w;
      if (want_q.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      w = want_q.pop_front();
      if (m != w.mode) report($sformatf("mode got %0d want %0d", m, w.mode));
      if (mc != w.changed)
        report($sformatf("mode_changed got %0d want %0d", mc, w.changed));
      if (t != w.tenths)
        report($sformatf("measured_tenths got %0d want %0d", t, w.tenths));
      if (sp != w.sp) report($sformatf("set_point got %0d want %0d", sp, w.sp));
    endtask

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic cmd_valid;
  logic cmd_ready;
  logic [1:0] opcode;
  logic [15:0] sensor_raw;
  logic res_valid;
  logic res_ready;
  logic [1:0] mode;
  logic mode_changed;
  logic signed [TEMP_W-1:0] measured_tenths;
  logic [SP_W-1:0] set_point;

  thermo_scoreboard sb;
  bit no_gaps;
  int unsigned idle_cycles;

  hysteresis_thermostat DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .opcode(opcode),
    .sensor_raw(sensor_raw),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .mode(mode),
    .mode_changed(mode_changed),
    .measured_tenths(measured_tenths),
    .set_point(set_point)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) sb.note_command(opcode, sensor_raw);
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (!rst && res_valid && res_ready)
      sb.check_result(mode, mode_changed, measured_tenths, set_point);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls
  initial begin
    int unsigned n;
    res_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = draw_gap();
      if (n != 0) begin
        @(negedge clk);
        res_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ready = 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [15:0] raw);
    int unsigned n;
    n = draw_gap();
    if (n != 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid  = 1'b1;
    opcode     = op;
    sensor_raw = raw;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_all(input int fhl, input int bnd, input int stp, input int mx,
                             input int mn);
    write_cfg(REG_FORCED_HEAT_LEVEL, 12'(fhl));
    write_cfg(REG_BAND, 12'(bnd));
    write_cfg(REG_SETPOINT_STEP, 12'(stp));
    write_cfg(REG_SETPOINT_MAX, 12'(mx));
    write_cfg(REG_SETPOINT_MIN, 12'(mn));
  endtask

  // raw word for a temperature mostly near the set point or the forced level
  function automatic logic [15:0] pick_raw();
    int r;
    int t;
    int w;
    r = $urandom_range(0, 99);
    w = int'(sb.band) + 6;
    if (r < 55) t = int'(sb.sp_q) + int'($urandom_range(0, 2 * w)) - w;
    else if (r < 70) t = int'(sb.heat_floor) + int'($urandom_range(0, 6)) - 3;
    else if (r < 85) t = int'($urandom_range(0, 1800)) - 550;
    else return 16'($urandom);
    return 16'((t * 16) / 10 + int'($urandom_range(0, 1)));
  endfunction

  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) send_cmd(OP_SAMPLE, pick_raw());
    else if (r < 83) send_cmd(OP_RAISE, 16'($urandom));
    else if (r < 96) send_cmd(OP_LOWER, 16'($urandom));
    else send_cmd(OP_UNUSED, 16'($urandom));
  endtask

  initial begin
    int a;
    int b;
    sb = new();
    no_gaps     = 1'b0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cmd_valid  = 1'b0;
    opcode     = OP_SAMPLE;
    sensor_raw = 16'h0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // conversion extremes and hysteresis at reset settings
    send_cmd(OP_SAMPLE, 16'h0000);
    send_cmd(OP_SAMPLE, 16'h7FFF);
    send_cmd(OP_SAMPLE, 16'h8000);
    send_cmd(OP_SAMPLE, 16'hFFFF);
    send_cmd(OP_SAMPLE, 16'h0160);
    send_cmd(OP_SAMPLE, 16'h0161);
    send_cmd(OP_SAMPLE, 16'h0158);
    send_cmd(OP_SAMPLE, 16'h0160);
    send_cmd(OP_SAMPLE, 16'h0168);
    send_cmd(OP_SAMPLE, 16'h0160);
    send_cmd(OP_SAMPLE, 16'h0098);
    send_cmd(OP_SAMPLE, 16'h009A);
    send_cmd(OP_UNUSED, 16'hA5A5);
    send_cmd(OP_RAISE, 16'h5A5A);
    send_cmd(OP_LOWER, 16'hFFFF);
    drain();

    // clamps, and a maximum below the minimum
    write_cfg(REG_SETPOINT_STEP, 12'd255);
    send_cmd(OP_RAISE, 16'h0000);
    send_cmd(OP_RAISE, 16'h0000);
    send_cmd(OP_LOWER, 16'h0000);
    send_cmd(OP_LOWER, 16'h0000);
    drain();
    write_cfg(REG_SETPOINT_MAX, 12'd50);
    send_cmd(OP_RAISE, 16'h0000);
    send_cmd(OP_LOWER, 16'h0000);
    drain();

    // zero band with the gap exactly zero
    write_cfg(REG_BAND, 12'd0);
    write_cfg(REG_FORCED_HEAT_LEVEL, 12'(-550));
    send_cmd(OP_SAMPLE, 16'h0000);
    send_cmd(OP_SAMPLE, 16'h00A0);
    send_cmd(OP_SAMPLE, 16'h00A0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_all(-550, 0, 1, 1250, 0);
        1: program_all(1250, 255, 255, 0, 1250);
        2: program_all(95, 5, 5, 390, 100);
        default: begin
          a = $urandom_range(0, 1250);
          b = $urandom_range(0, 1250);
          if (a < b && $urandom_range(0, 3) != 0) begin
            int c;
            c = a;
            a = b;
            b = c;
          end
          program_all(int'($urandom_range(0, 1800)) - 550,
                      ($urandom_range(0, 1) != 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(0, 255),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20)
                                                  : $urandom_range(1, 255),
                      a, b);
        end
      endcase
      no_gaps = (p == 3 || p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p == 4) drain();
        random_cmd();
      end
      drain();
    end
    no_gaps = 1'b0;

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
